>>> hdl/dvt_pkg.sv
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and codes of the distance-vector routing table.
// ----------------------------------------------------------------------------
`default_nettype none

package dvt_pkg;

    localparam int ID_W   = 8;
    localparam int COST_W = 8;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_ADV  = 2'd1,
        OP_REM  = 2'd2,
        OP_ADD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOT_NB = 2'd1,
        ST_FULL   = 2'd2,
        ST_OWN_ID = 2'd3
    } t_status;

    // Command handed from the front queue to the table sequencer.
    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   from_node;
        logic [ID_W-1:0]   dest;
        logic [COST_W-1:0] new_cost;
        logic              is_self;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] cost;
    } t_route;

endpackage

`default_nettype wire

>>> hdl/dvt_front.sv
// ----------------------------------------------------------------------------
// dvt_front
// Accepts input items, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dvt_front #(
    parameter int MAX_COST = 255
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_op,
    input  wire logic [7:0]           i_from_node,
    input  wire logic [7:0]           i_dest,
    input  wire logic [7:0]           i_adv_cost,
    input  wire logic [7:0]           i_own_id,
    output logic                      o_cmd_valid,
    input  wire logic                 i_cmd_ready,
    output dvt_pkg::t_cmd             o_cmd
);
    import dvt_pkg::*;

    localparam logic [COST_W:0] MaxCost = (COST_W+1)'(MAX_COST);

    t_cmd            r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    t_cmd            w_cmd;
    logic [COST_W:0] w_sum;
    logic            w_push, w_pop;

    always_comb begin
        w_sum           = {1'b0, i_adv_cost} + 1'b1;
        w_cmd.op        = t_op'(i_op);
        w_cmd.from_node = i_from_node;
        w_cmd.dest      = i_dest;
        w_cmd.new_cost  = (w_sum > MaxCost) ? MaxCost[COST_W-1:0] : w_sum[COST_W-1:0];
        w_cmd.is_self   = (i_dest == i_own_id);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

endmodule

`default_nettype wire

>>> hdl/dvt_back.sv
// ----------------------------------------------------------------------------
// dvt_back
// Table sequencer: walks, updates, compacts and reports the route memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dvt_back #(
    parameter int MAX_ROUTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  dvt_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]  i_own_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_entry_dest,
    output logic [7:0]       o_entry_hop,
    output logic             o_hop_valid,
    output logic [7:0]       o_entry_cost,
    output logic [1:0]       o_status,
    output logic             o_last
);
    import dvt_pkg::*;

    localparam int IW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam logic [CW-1:0] MaxRoutes = CW'(MAX_ROUTES);

    typedef enum logic [3:0] {
        S_IDLE, S_RSELF, S_RFETCH, S_REMIT, S_FETCH, S_CMP, S_SFETCH, S_SWRITE, S_RESP
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [CW-1:0]   r_idx, r_count;
    t_status         r_st;
    t_route          r_mem [MAX_ROUTES];
    t_route          r_rdata;
    logic [IW-1:0]   w_raddr, w_waddr;
    logic            w_re, w_we;
    t_route          w_wdata;
    logic [CW-1:0]   w_idx1;
    logic            w_load, w_match, w_emit;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_load      = !o_valid || i_ready;
    // A result is loaded into the output register this cycle.
    assign w_emit      = w_load && (r_state inside {S_RSELF, S_REMIT, S_RESP});
    assign w_idx1      = r_idx + 1'b1;
    assign w_match     = (r_rdata.dest == r_cmd.dest) &&
                         ((r_cmd.op != OP_REM) || (r_rdata.cost == COST_W'(1)));

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx[IW-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_wdata = '{dest: r_cmd.dest, hop: r_cmd.dest, cost: COST_W'(1)};
        case (r_state)
            S_RFETCH: w_re = 1'b1;
            S_FETCH: begin
                if (r_idx != r_count) begin
                    w_re = 1'b1;
                end else if (r_cmd.op != OP_REM && r_count != MaxRoutes) begin
                    // Unknown destination: append at the end of the table.
                    w_we    = 1'b1;
                    w_waddr = r_count[IW-1:0];
                    if (r_cmd.op == OP_ADV)
                        w_wdata = '{dest: r_cmd.dest, hop: r_cmd.from_node,
                                    cost: r_cmd.new_cost};
                end
            end
            S_CMP: begin
                if (w_match && r_cmd.op == OP_ADD) begin
                    w_we = 1'b1;
                end else if (w_match && r_cmd.op == OP_ADV &&
                             (r_cmd.new_cost < r_rdata.cost ||
                              r_rdata.hop == r_cmd.from_node)) begin
                    w_we    = 1'b1;
                    w_wdata = '{dest: r_cmd.dest, hop: r_cmd.from_node,
                                cost: r_cmd.new_cost};
                end
            end
            S_SFETCH: begin
                w_re    = (w_idx1 < r_count);
                w_raddr = w_idx1[IW-1:0];
            end
            S_SWRITE: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && !w_emit) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_st  <= ST_OK;
                        case (i_cmd.op)
                            OP_READ: r_state <= S_RSELF;
                            OP_REM:  r_state <= S_FETCH;
                            default: begin
                                if (i_cmd.is_self) begin
                                    r_st    <= (i_cmd.op == OP_ADD) ? ST_OWN_ID : ST_OK;
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_FETCH;
                                end
                            end
                        endcase
                    end
                end
                S_RSELF: begin
                    if (w_load) begin
                        o_valid      <= 1'b1;
                        o_entry_dest <= i_own_id;
                        o_entry_hop  <= '0;
                        o_hop_valid  <= 1'b0;
                        o_entry_cost <= '0;
                        o_status     <= ST_OK;
                        o_last       <= (r_count == '0);
                        r_state      <= (r_count == '0) ? S_IDLE : S_RFETCH;
                    end
                end
                S_RFETCH: r_state <= S_REMIT;
                S_REMIT: begin
                    if (w_load) begin
                        o_valid      <= 1'b1;
                        o_entry_dest <= r_rdata.dest;
                        o_entry_hop  <= r_rdata.hop;
                        o_hop_valid  <= 1'b1;
                        o_entry_cost <= r_rdata.cost;
                        o_status     <= ST_OK;
                        o_last       <= (w_idx1 == r_count);
                        r_idx        <= w_idx1;
                        r_state      <= (w_idx1 == r_count) ? S_IDLE : S_RFETCH;
                    end
                end
                S_FETCH: begin
                    if (r_idx != r_count) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_RESP;
                        if (r_cmd.op == OP_REM)
                            r_st <= ST_NOT_NB;
                        else if (r_count == MaxRoutes)
                            r_st <= ST_FULL;
                        else
                            r_count <= r_count + 1'b1;
                    end
                end
                S_CMP: begin
                    if (!w_match) begin
                        r_idx   <= w_idx1;
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= (r_cmd.op == OP_REM) ? S_SFETCH : S_RESP;
                    end
                end
                S_SFETCH: begin
                    if (w_idx1 < r_count) begin
                        r_state <= S_SWRITE;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_RESP;
                    end
                end
                S_SWRITE: begin
                    r_idx   <= w_idx1;
                    r_state <= S_SFETCH;
                end
                S_RESP: begin
                    if (w_load) begin
                        o_valid      <= 1'b1;
                        o_entry_dest <= '0;
                        o_entry_hop  <= '0;
                        o_hop_valid  <= 1'b0;
                        o_entry_cost <= '0;
                        o_status     <= r_st;
                        o_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/distance_vector_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_table_unit
// Distance-vector routing table with a queued front end and a table walker.
//
// Channel   Signals                          Role
// input     i_valid / o_ready, i_op..        table operation
// output    o_valid / i_ready, o_entry_..    entries and status
// config    psel/penable/pwrite/paddr        own_id at address 0
//
// A read returns the own-id entry, then fetches and emits each stored entry
// (S_RFETCH, S_REMIT); an update walks the table through S_FETCH and S_CMP,
// and a removal moves each later entry down through S_SFETCH and S_SWRITE.
// A two-entry queue keeps taking items while the walker is busy, until full.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled output holds the walker only when it has a result to deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_table_unit #(
    parameter int MAX_ROUTES = 32,
    parameter int MAX_COST   = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_from_node,
    input  wire logic [7:0]  i_dest,
    input  wire logic [7:0]  i_adv_cost,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_entry_dest,
    output logic [7:0]       o_entry_hop,
    output logic             o_hop_valid,
    output logic [7:0]       o_entry_cost,
    output logic [1:0]       o_status,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dvt_pkg::*;

    logic [7:0] r_own_id;
    logic       w_cmd_valid, w_cmd_ready;
    t_cmd       w_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_own_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_own_id <= pwdata[7:0];
        end
    end

    dvt_front #(.MAX_COST(MAX_COST)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_from_node(i_from_node), .i_dest(i_dest),
        .i_adv_cost(i_adv_cost), .i_own_id(r_own_id),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    dvt_back #(.MAX_ROUTES(MAX_ROUTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .i_own_id(r_own_id),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_entry_dest(o_entry_dest), .o_entry_hop(o_entry_hop),
        .o_hop_valid(o_hop_valid), .o_entry_cost(o_entry_cost),
        .o_status(o_status), .o_last(o_last)
    );

endmodule

`default_nettype wire

>>> hdl/dvt_checker.sv
// ----------------------------------------------------------------------------
// dvt_checker
// Port-level checks of the routing table result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dvt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_hop_valid,
    input wire logic [7:0] o_entry_cost,
    input wire logic [1:0] o_status,
    input wire logic       o_last
);
    import dvt_pkg::*;

    // A stalled result keeps its status and end mark.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Stored entries only come out of a read, which always reports ok.
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hop_valid |-> o_status == ST_OK && o_entry_cost != 8'd0)
        else $error("stored entry with bad status or zero cost");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && !o_hop_valid)
        else $error("error status not on a single final result");

endmodule

bind distance_vector_table_unit dvt_checker u_dvt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_hop_valid(o_hop_valid), .o_entry_cost(o_entry_cost),
    .o_status(o_status), .o_last(o_last)
);

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance-vector routing table unit.
// An internal table model predicts every entry and status. Directed tests
// cover the corner cases, then random traffic runs under varied flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 32;
    localparam int COST_CAP    = 255;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 300;

    typedef struct {
        logic [7:0] dest;
        logic [7:0] hop;
        logic       hop_valid;
        logic [7:0] cost;
        t_status    status;
        logic       last;
    } t_entry_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = 2'd0;
    logic [7:0]  i_from_node = 8'd0;
    logic [7:0]  i_dest = 8'd0;
    logic [7:0]  i_adv_cost = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_entry_dest;
    logic [7:0]  o_entry_hop;
    logic        o_hop_valid;
    logic [7:0]  o_entry_cost;
    logic [1:0]  o_status;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    distance_vector_table_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the routing table.
    logic [7:0] tbl_dest [TABLE_DEPTH];
    logic [7:0] tbl_hop  [TABLE_DEPTH];
    logic [7:0] tbl_cost [TABLE_DEPTH];
    int         tbl_count = 0;
    logic       nbr_set [256];
    logic [7:0] node_id = 8'd0;

    t_entry_out pending_entries[$];
    int error_count = 0;
    int mismatch_count = 0;
    int sender_idle = 0;
    int receiver_stall = 0;
    int quiet_cycles = 0;

    function automatic int lookup_dest(logic [7:0] d);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_dest[i] == d) return i;
        return -1;
    endfunction

    function automatic void expect_entry(t_entry_out e);
        pending_entries.insert(pending_entries.size(), e);
    endfunction

    function automatic void push_status(t_status st);
        t_entry_out e;
        e = '{dest: 8'd0, hop: 8'd0, hop_valid: 1'b0, cost: 8'd0, status: st, last: 1'b1};
        expect_entry(e);
    endfunction

    function automatic void apply_operation(t_op op, logic [7:0] from, logic [7:0] d,
                                            logic [7:0] adv);
        t_entry_out e;
        int idx;
        int nc;
        bit hit;
        t_status st;
        st = ST_OK;
        case (op)
            OP_READ: begin
                e = '{dest: node_id, hop: 8'd0, hop_valid: 1'b0, cost: 8'd0,
                      status: ST_OK, last: (tbl_count == 0)};
                expect_entry(e);
                for (int i = 0; i < tbl_count; i++) begin
                    e = '{dest: tbl_dest[i], hop: tbl_hop[i], hop_valid: 1'b1,
                          cost: tbl_cost[i], status: ST_OK, last: (i + 1 == tbl_count)};
                    expect_entry(e);
                end
                return;
            end
            OP_ADV: begin
                nc = int'(adv) + 1;
                if (nc > COST_CAP) nc = COST_CAP;
                if (d != node_id) begin
                    idx = lookup_dest(d);
                    if (idx >= 0) begin
                        if (nc < tbl_cost[idx]) begin
                            tbl_cost[idx] = nc[7:0];
                            tbl_hop[idx] = from;
                        end else if (tbl_hop[idx] == from) begin
                            tbl_cost[idx] = nc[7:0];
                        end
                    end else if (tbl_count < TABLE_DEPTH) begin
                        tbl_dest[tbl_count] = d;
                        tbl_hop[tbl_count] = from;
                        tbl_cost[tbl_count] = nc[7:0];
                        tbl_count++;
                    end else begin
                        st = ST_FULL;
                    end
                end
            end
            OP_REM: begin
                hit = 1'b0;
                for (int i = 0; i < tbl_count && !hit; i++) begin
                    if (tbl_dest[i] == d && tbl_cost[i] == 8'd1) begin
                        for (int j = i; j + 1 < tbl_count; j++) begin
                            tbl_dest[j] = tbl_dest[j+1];
                            tbl_hop[j] = tbl_hop[j+1];
                            tbl_cost[j] = tbl_cost[j+1];
                        end
                        tbl_count--;
                        hit = 1'b1;
                    end
                end
                if (hit) nbr_set[d] = 1'b0;
                else st = ST_NOT_NB;
            end
            default: begin
                if (d == node_id) begin
                    st = ST_OWN_ID;
                end else begin
                    idx = lookup_dest(d);
                    if (idx >= 0) begin
                        tbl_hop[idx] = d;
                        tbl_cost[idx] = 8'd1;
                        nbr_set[d] = 1'b1;
                    end else if (tbl_count < TABLE_DEPTH) begin
                        tbl_dest[tbl_count] = d;
                        tbl_hop[tbl_count] = d;
                        tbl_cost[tbl_count] = 8'd1;
                        tbl_count++;
                        nbr_set[d] = 1'b1;
                    end else begin
                        st = ST_FULL;
                    end
                end
            end
        endcase
        push_status(st);
    endfunction

    task automatic send_op(t_op op, logic [7:0] from, logic [7:0] d, logic [7:0] adv);
        while ($urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_from_node <= from;
        i_dest <= d;
        i_adv_cost <= adv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_operation(op, from, d, adv);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_own_id(logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {$urandom_range(16777215), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        node_id = v;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall);
    end

    // Result checker against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_entry_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_entries.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: dest %0d status %0d",
                        o_entry_dest, o_status);
            end else begin
                e = pending_entries.pop_front();
                if (o_entry_dest !== e.dest || o_entry_hop !== e.hop
                        || o_hop_valid !== e.hop_valid || o_entry_cost !== e.cost
                        || o_status !== e.status || o_last !== e.last) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp d%0d h%0d hv%0d c%0d s%0d l%0d,",
                            e.dest, e.hop, e.hop_valid, e.cost, e.status, e.last,
                            " got d%0d h%0d hv%0d c%0d s%0d l%0d",
                            o_entry_dest, o_entry_hop, o_hop_valid, o_entry_cost,
                            o_status, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_corner_cases();
        write_own_id(8'd0);
        send_op(OP_READ, 8'd0, 8'd0, 8'd0);
        send_op(OP_ADD, 8'd0, 8'd0, 8'd0);           // own id rejected
        send_op(OP_REM, 8'd0, 8'd77, 8'd0);          // not a neighbour
        send_op(OP_ADD, 8'd0, 8'd10, 8'd0);
        send_op(OP_ADD, 8'd0, 8'd10, 8'd0);          // no duplicate
        send_op(OP_ADD, 8'd0, 8'd255, 8'd0);
        send_op(OP_ADV, 8'd10, 8'd20, 8'd3);
        send_op(OP_ADV, 8'd255, 8'd20, 8'd0);        // strictly cheaper
        send_op(OP_ADV, 8'd255, 8'd20, 8'd255);      // refresh, saturated
        send_op(OP_ADV, 8'd10, 8'd20, 8'd2);
        send_op(OP_ADV, 8'd10, 8'd0, 8'd5);          // own id advertised
        send_op(OP_ADV, 8'd200, 8'd30, 8'd254);
        send_op(OP_ADV, 8'd0, 8'd31, 8'd255);
        send_op(OP_READ, 8'd0, 8'd0, 8'd0);
        send_op(OP_REM, 8'd0, 8'd10, 8'd0);
        send_op(OP_REM, 8'd0, 8'd10, 8'd0);
        send_op(OP_REM, 8'd0, 8'd20, 8'd0);
        send_op(OP_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();
    endtask

    task automatic test_full_table();
        write_own_id(8'd255);
        for (int i = 0; tbl_count < TABLE_DEPTH; i++)
            send_op(OP_ADD, 8'd0, 8'(100 + i), 8'd0);
        send_op(OP_ADD, 8'd0, 8'd7, 8'd0);           // full, rejected
        send_op(OP_ADV, 8'd100, 8'd8, 8'd1);         // full, dropped
        send_op(OP_ADD, 8'd0, 8'd255, 8'd0);
        send_op(OP_READ, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 28; i++)
            send_op(OP_REM, 8'd0, 8'(100 + i), 8'd0);
        send_op(OP_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();
    endtask

    function automatic logic [7:0] pick_id();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(47));
    endfunction

    task automatic test_random_traffic(int n_items, logic [7:0] id);
        int sel;
        logic [7:0] d;
        logic [7:0] from;
        write_own_id(id);
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            d = pick_id();
            if (sel < 12) begin
                send_op(OP_READ, 8'($urandom_range(255)), d, 8'($urandom_range(255)));
            end else if (sel < 55) begin
                from = ($urandom_range(3) == 0) ? pick_id()
                       : (tbl_count > 0 ? tbl_hop[$urandom_range(tbl_count - 1)] : pick_id());
                send_op(OP_ADV, from, d,
                        ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(15)));
            end else if (sel < 75) begin
                if (tbl_count > 0 && $urandom_range(1)) d = tbl_dest[$urandom_range(tbl_count - 1)];
                send_op(OP_REM, 8'($urandom_range(255)), d, 8'($urandom_range(255)));
            end else begin
                if ($urandom_range(15) == 0) d = node_id;
                send_op(OP_ADD, 8'($urandom_range(255)), d, 8'($urandom_range(255)));
            end
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < 256; i++) nbr_set[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle = 21;
        receiver_stall = 82;
        test_corner_cases();
        test_full_table();
        test_random_traffic(124, 8'd255);
        sender_idle = 82;
        receiver_stall = 21;
        test_random_traffic(124, 8'd0);
        sender_idle = 0;
        receiver_stall = 0;
        test_random_traffic(124, 8'($urandom_range(1, 254)));
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
